>>> rtl/core/lnd_pkg.sv
package lnd_pkg;

    localparam int unsigned DATA_W = 32;
    localparam int unsigned SUM_W  = 50;

    localparam logic [1:0] CMD_RECEIVE = 2'd0;
    localparam logic [1:0] CMD_TICK    = 2'd1;
    localparam logic [1:0] CMD_ADD     = 2'd2;

    localparam logic [2:0] REG_LEAK      = 3'd0;
    localparam logic [2:0] REG_GAIN      = 3'd1;
    localparam logic [2:0] REG_EXCIT     = 3'd2;
    localparam logic [2:0] REG_INHIB     = 3'd3;
    localparam logic [2:0] REG_THRESHOLD = 3'd4;
    localparam logic [2:0] REG_REFRACT   = 3'd5;

    typedef struct packed {
        logic        [15:0] leak;
        logic        [30:0] gain;
        logic signed [31:0] excit;
        logic signed [31:0] inhib;
        logic signed [31:0] threshold;
        logic        [7:0]  steps;
    } t_cfg;

    typedef struct packed {
        logic [1:0]         cmd;
        logic               inhibitory;
        logic signed [31:0] amount;
    } t_item;

    typedef struct packed {
        logic               spiked;
        logic signed [31:0] potential;
        logic               refractory;
    } t_result;

    typedef struct packed {
        logic               en;
        logic signed [31:0] data;
    } t_ring_wr;

    function automatic logic signed [DATA_W-1:0] sat_sum(input logic signed [SUM_W-1:0] v);
        logic signed [DATA_W-1:0] r;
        if (v > SUM_W'(64'sh7FFF_FFFF)) begin
            r = 32'sh7FFF_FFFF;
        end else if (v < -SUM_W'(64'sh8000_0000)) begin
            r = 32'sh8000_0000;
        end else begin
            r = v[DATA_W-1:0];
        end
        return r;
    endfunction

endpackage

>>> rtl/core/lif_neuron_delay_ring.sv
// Leaky integrate-and-fire neuron in Q16.16 with a ring of DELAY_SLOTS slots that collect
// delayed spike input. Items enter on the in channel (cmd 0 receive, 1 tick, 2 add) and each
// returns exactly one result on the out channel. One item is accepted per cycle unless the
// output stalls. The ring slot is read at the accept edge and the item is held in the stage
// register; when it advances, the tick update (two multiplies, a saturating add and the
// threshold compare) runs combinationally against the membrane register and writes the
// result register. The ring is a memory with one write and one read port and a per-slot
// valid bit, so no clearing pass is needed after reset. Write configuration registers through
// the cfg channel only while idle; the block itself does not enforce this.
module lif_neuron_delay_ring
    import lnd_pkg::*;
#(
    parameter int unsigned DELAY_SLOTS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_cmd,
    input  logic [3:0]         i_delay,
    input  logic               i_inhibitory,
    input  logic signed [31:0] i_amount,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_spiked,
    output logic signed [31:0] o_potential,
    output logic               o_refractory,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    t_cfg               s_cfg;
    t_ring_wr           s_wr;
    t_result            s_result;
    logic signed [31:0] s_slot;
    logic               s_accept;
    logic               s_advance;

    logic    r_s1_valid;
    t_item   r_s1;
    logic    r_out_valid;
    t_result r_out;

    logic n_s1_valid;
    logic n_out_valid;

    assign s_advance  = r_s1_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_s1_valid || s_advance;
    assign s_accept   = i_in_valid && o_in_ready;

    assign o_out_valid  = r_out_valid;
    assign o_spiked     = r_out.spiked;
    assign o_potential  = r_out.potential;
    assign o_refractory = r_out.refractory;

    lnd_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg_ready (o_cfg_ready),
        .o_cfg       (s_cfg)
    );

    lnd_ring #(
        .DELAY_SLOTS (DELAY_SLOTS)
    ) u_ring (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (s_accept),
        .i_cmd    (i_cmd),
        .i_delay  (i_delay),
        .i_wr     (s_wr),
        .o_slot   (s_slot)
    );

    lnd_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (s_advance),
        .i_item    (r_s1),
        .i_slot    (s_slot),
        .i_cfg     (s_cfg),
        .o_wr      (s_wr),
        .o_result  (s_result)
    );

    always_comb begin
        n_s1_valid  = s_accept ? 1'b1 : (s_advance ? 1'b0 : r_s1_valid);
        n_out_valid = s_advance ? 1'b1 : (i_out_ready ? 1'b0 : r_out_valid);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_s1_valid  <= n_s1_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_accept) begin
            r_s1.cmd        <= i_cmd;
            r_s1.inhibitory <= i_inhibitory;
            r_s1.amount     <= i_amount;
        end
        if (s_advance) begin
            r_out <= s_result;
        end
    end

`ifndef SYNTHESIS
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_out_valid |-> o_in_ready)
        else $error("input not ready with empty output register");

    a_spike_resets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.spiked |-> (r_out.potential == 32'sd0))
        else $error("spike reported with nonzero potential");

    a_ring_write_on_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_wr.en |-> s_advance)
        else $error("ring written without a stage transfer");

    a_stall_blocks_input: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid && r_out_valid && !i_out_ready |-> !o_in_ready)
        else $error("input accepted while pipeline stalled");
`endif

endmodule

>>> rtl/core/lnd_cfg_regs.sv
module lnd_cfg_regs
    import lnd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_valid,
    input  logic [2:0]  i_cfg_index,
    input  logic [31:0] i_cfg_data,
    output logic        o_cfg_ready,
    output t_cfg        o_cfg
);

    t_cfg r_cfg;

    assign o_cfg_ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.leak      <= 16'd65209;
            r_cfg.gain      <= 31'd6540;
            r_cfg.excit     <= 32'sd6554;
            r_cfg.inhib     <= -32'sd32768;
            r_cfg.threshold <= 32'sd1310720;
            r_cfg.steps     <= 8'd20;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_LEAK:      r_cfg.leak      <= i_cfg_data[15:0];
                REG_GAIN:      r_cfg.gain      <= i_cfg_data[30:0];
                REG_EXCIT:     r_cfg.excit     <= $signed(i_cfg_data);
                REG_INHIB:     r_cfg.inhib     <= $signed(i_cfg_data);
                REG_THRESHOLD: r_cfg.threshold <= $signed(i_cfg_data);
                REG_REFRACT:   r_cfg.steps     <= i_cfg_data[7:0];
                default: begin
                end
            endcase
        end
    end

endmodule

>>> rtl/core/lnd_ring.sv
module lnd_ring
    import lnd_pkg::*;
#(
    parameter int unsigned DELAY_SLOTS = 16
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_accept,
    input  logic [1:0]         i_cmd,
    input  logic [3:0]         i_delay,
    input  t_ring_wr           i_wr,
    output logic signed [31:0] o_slot
);

    localparam int unsigned PW = (DELAY_SLOTS > 1) ? $clog2(DELAY_SLOTS) : 1;
    localparam int unsigned SW = PW + 5;
    localparam logic [SW-1:0] N_W = SW'(DELAY_SLOTS);
    localparam logic [PW-1:0] PTR_LAST = PW'(DELAY_SLOTS - 1);

    logic [PW-1:0]          r_ptr;
    logic [PW-1:0]          r_addr;
    logic [DELAY_SLOTS-1:0] r_vld;
    logic signed [31:0]     r_mem [DELAY_SLOTS];
    logic signed [31:0]     r_rd_data;
    logic                   r_rd_vld;

    logic [SW-1:0] s_rem;
    logic [SW-1:0] s_sum;
    logic [PW-1:0] s_addr;
    logic          s_bypass;

    // delay mod slots by shifted compare-subtract, then one wrap of the sum
    always_comb begin
        s_rem = SW'(i_delay);
        for (int k = 3; k >= 0; k--) begin
            if (s_rem >= (N_W << k)) begin
                s_rem = s_rem - (N_W << k);
            end
        end
        s_sum = SW'(r_ptr) + s_rem;
        if (s_sum >= N_W) begin
            s_sum = s_sum - N_W;
        end
        s_addr   = (i_cmd == CMD_TICK) ? r_ptr : s_sum[PW-1:0];
        s_bypass = i_wr.en && (r_addr == s_addr);
    end

    assign o_slot = r_rd_vld ? r_rd_data : 32'sd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr <= '0;
            r_vld <= '0;
        end else begin
            if (i_accept && (i_cmd == CMD_TICK)) begin
                r_ptr <= (r_ptr == PTR_LAST) ? '0 : r_ptr + 1'b1;
            end
            if (i_wr.en) begin
                r_vld[r_addr] <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            r_mem[r_addr] <= i_wr.data;
        end
    end

    // read with bypass of the write retiring in the same cycle
    always_ff @(posedge i_clk) begin
        if (i_accept) begin
            r_addr <= s_addr;
            if (s_bypass) begin
                r_rd_data <= i_wr.data;
                r_rd_vld  <= 1'b1;
            end else begin
                r_rd_data <= r_mem[s_addr];
                r_rd_vld  <= r_vld[s_addr];
            end
        end
    end

endmodule

>>> rtl/core/lnd_core.sv
module lnd_core
    import lnd_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  t_item              i_item,
    input  logic signed [31:0] i_slot,
    input  t_cfg               i_cfg,
    output t_ring_wr           o_wr,
    output t_result            o_result
);

    logic signed [31:0] r_membrane;
    logic [7:0]         r_refr;

    logic signed [31:0] n_membrane;
    logic [7:0]         n_refr;

    logic signed [48:0]      s_p_leak;
    logic signed [63:0]      s_p_gain;
    logic signed [SUM_W-1:0] s_sum;
    logic signed [31:0]      s_integ;
    logic signed [31:0]      s_weight;
    logic                    s_spike;

    always_comb begin
        s_p_leak = $signed({1'b0, i_cfg.leak}) * r_membrane;
        s_p_gain = $signed({1'b0, i_cfg.gain}) * i_item.amount;
        s_sum    = $signed({{17{s_p_leak[48]}}, s_p_leak[48:16]})
                 + $signed({{2{s_p_gain[63]}}, s_p_gain[63:16]})
                 + $signed({{18{i_slot[31]}}, i_slot});
        s_integ  = (r_refr == 8'd0) ? sat_sum(s_sum) : r_membrane;
        s_spike  = s_integ > i_cfg.threshold;
        s_weight = i_item.inhibitory ? i_cfg.inhib : i_cfg.excit;

        n_membrane = r_membrane;
        n_refr     = r_refr;
        o_wr.en    = 1'b0;
        o_wr.data  = 32'sd0;
        case (i_item.cmd)
            CMD_RECEIVE: begin
                o_wr.en   = i_advance;
                o_wr.data = sat_sum(SUM_W'(i_slot) + SUM_W'(s_weight));
            end
            CMD_TICK: begin
                o_wr.en = i_advance;
                if (s_spike) begin
                    n_membrane = 32'sd0;
                    n_refr     = i_cfg.steps;
                end else begin
                    n_membrane = s_integ;
                    n_refr     = (r_refr == 8'd0) ? 8'd0 : r_refr - 8'd1;
                end
            end
            CMD_ADD: begin
                n_membrane = sat_sum(SUM_W'(r_membrane) + SUM_W'(i_item.amount));
            end
            default: begin
            end
        endcase

        o_result.spiked     = (i_item.cmd == CMD_TICK) && s_spike;
        o_result.potential  = n_membrane;
        o_result.refractory = n_refr != 8'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_membrane <= 32'sd0;
            r_refr     <= 8'd0;
        end else if (i_advance) begin
            r_membrane <= n_membrane;
            r_refr     <= n_refr;
        end
    end

endmodule
